>>> design/ptr_pkg.sv
// Shared types, constants and the voltage table for the Peltier regulator.
// No dependencies; imported by every module of the block except ptr_ram.
`timescale 1ns / 1ps

package ptr_pkg;

  // Voltage table: entry i stands for temperature i - TEMP_OFFSET.
  localparam int VOLT_LEN    = 67;
  localparam int IDX_W       = 7;
  localparam logic [IDX_W-1:0] VOLT_LAST = IDX_W'(VOLT_LEN - 1);
  localparam logic [7:0] VOLT_TOP    = 8'd247;
  localparam logic [7:0] VOLT_BOTTOM = 8'd24;
  localparam logic [IDX_W-1:0] TEMP_OFFSET = 7'd10;

  localparam logic signed [6:0] TEMP_MIN = -7'sd10;
  localparam logic signed [6:0] TEMP_MAX = 7'sd56;

  // Drive levels
  localparam logic [6:0] DUTY_COOL_COARSE = 7'd110;
  localparam logic [6:0] DUTY_HEAT_COARSE = 7'd70;
  localparam logic [6:0] FINE_START       = 7'd50;
  localparam logic [6:0] FINE_START_HEAT  = 7'd15;
  localparam logic [6:0] COOL_FLOOR_TEST  = 7'd25;
  localparam logic [6:0] COOL_FLOOR       = 7'd20;
  localparam logic [6:0] COOL_STEP        = 7'd5;
  localparam logic [6:0] HEAT_FLOOR_TEST  = 7'd5;
  localparam logic [6:0] HEAT_STEP        = 7'd2;
  localparam logic [6:0] HEAT_CAP         = 7'd50;

  // Polarity codes
  localparam logic [1:0] POL_NONE = 2'd0;
  localparam logic [1:0] POL_HEAT = 2'd1;
  localparam logic [1:0] POL_COOL = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL = 1'd1;
  localparam logic signed [6:0] TEMP_CFG_RESET = 7'sd20;

  // State memory geometry
  localparam int STATE_DEPTH = 1;
  localparam int STATE_AW    = 1;
  localparam int STATE_W     = 10;

  typedef struct packed {
    logic       primed;
    logic [1:0] polarity;
    logic [6:0] fine_level;
  } reg_state_t;

  typedef struct packed {
    logic       busy;
    logic       done;
  } scan_stat_t;

  typedef struct packed {
    logic [1:0] polarity;
    logic [6:0] duty;
    logic       fine_region;
  } reg_out_t;

  function automatic logic [7:0] volt_entry(input logic [IDX_W-1:0] idx);
    logic [7:0] v;
    case (idx)
      7'd0:  v = 8'd247;  7'd1:  v = 8'd240;  7'd2:  v = 8'd234;  7'd3:  v = 8'd227;
      7'd4:  v = 8'd221;  7'd5:  v = 8'd214;  7'd6:  v = 8'd208;  7'd7:  v = 8'd202;
      7'd8:  v = 8'd196;  7'd9:  v = 8'd190;  7'd10: v = 8'd184;  7'd11: v = 8'd178;
      7'd12: v = 8'd172;  7'd13: v = 8'd166;  7'd14: v = 8'd161;  7'd15: v = 8'd155;
      7'd16: v = 8'd150;  7'd17: v = 8'd145;  7'd18: v = 8'd140;  7'd19: v = 8'd135;
      7'd20: v = 8'd131;  7'd21: v = 8'd126;  7'd22: v = 8'd122;  7'd23: v = 8'd117;
      7'd24: v = 8'd113;  7'd25: v = 8'd109;  7'd26: v = 8'd105;  7'd27: v = 8'd101;
      7'd28: v = 8'd98;   7'd29: v = 8'd94;   7'd30: v = 8'd91;   7'd31: v = 8'd87;
      7'd32: v = 8'd84;   7'd33: v = 8'd81;   7'd34: v = 8'd78;   7'd35: v = 8'd76;
      7'd36: v = 8'd74;   7'd37: v = 8'd71;   7'd38: v = 8'd68;   7'd39: v = 8'd66;
      7'd40: v = 8'd63;   7'd41: v = 8'd61;   7'd42: v = 8'd59;   7'd43: v = 8'd57;
      7'd44: v = 8'd54;   7'd45: v = 8'd52;   7'd46: v = 8'd51;   7'd47: v = 8'd49;
      7'd48: v = 8'd47;   7'd49: v = 8'd45;   7'd50: v = 8'd44;   7'd51: v = 8'd42;
      7'd52: v = 8'd40;   7'd53: v = 8'd39;   7'd54: v = 8'd38;   7'd55: v = 8'd36;
      7'd56: v = 8'd35;   7'd57: v = 8'd34;   7'd58: v = 8'd33;   7'd59: v = 8'd31;
      7'd60: v = 8'd30;   7'd61: v = 8'd29;   7'd62: v = 8'd28;   7'd63: v = 8'd27;
      7'd64: v = 8'd26;   7'd65: v = 8'd25;   7'd66: v = 8'd24;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

>>> design/ptr_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps

module ptr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/ptr_scan.sv
// Serial nearest-entry search of the voltage table, one entry per cycle.
// Depends on ptr_pkg (table function, scan status type).
`timescale 1ns / 1ps

module ptr_scan
  import ptr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [7:0]              sample,
  output scan_stat_t              stat,
  output logic signed [6:0]       temp
);

  logic [7:0]       smp;
  logic [IDX_W-1:0] idx;
  logic             busy;
  logic             done;

  logic [IDX_W-1:0] idx_prev;
  logic [7:0]       v_cur;
  logic [7:0]       v_prev;
  logic [7:0]       d_below;
  logic [7:0]       d_above;
  logic             more;

  assign idx_prev = idx - 7'd1;
  assign v_cur    = volt_entry(idx);
  assign v_prev   = volt_entry(idx_prev);
  // in-range samples satisfy v_cur <= smp < v_prev at the stop point
  assign d_below  = smp - v_cur;
  assign d_above  = v_prev - smp;
  assign more     = (idx < VOLT_LAST) && (smp < v_cur);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      smp <= sample;
      idx <= 7'd1;
      if (sample >= VOLT_TOP) begin
        temp <= TEMP_MIN;
        busy <= 1'b0;
        done <= 1'b1;
      end else if (sample < VOLT_BOTTOM) begin
        temp <= TEMP_MAX;
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        busy <= 1'b1;
        done <= 1'b0;
      end
    end else if (busy) begin
      if (more) begin
        idx <= idx + 7'd1;
      end else begin
        busy <= 1'b0;
        done <= 1'b1;
        // ties go to the later entry
        if (d_below > d_above) begin
          temp <= $signed(idx_prev - TEMP_OFFSET);
        end else begin
          temp <= $signed(idx - TEMP_OFFSET);
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

>>> design/ptr_rules.sv
// Coarse/fine regulation rules: next state word and drive outputs.
// Depends on ptr_pkg (state and output types, drive constants).
`timescale 1ns / 1ps

module ptr_rules
  import ptr_pkg::*;
(
  input  logic signed [6:0] target_temp,
  input  logic signed [6:0] initial_temp,
  input  logic signed [6:0] temp,
  input  reg_state_t        st,
  output reg_state_t        st_next,
  output reg_out_t          res
);

  logic              mode_cool;
  logic              mode_heat;
  logic signed [7:0] err;
  logic [6:0]        lvl;
  logic [6:0]        lvl_up;

  assign mode_cool = target_temp < initial_temp;
  assign mode_heat = target_temp > initial_temp;
  assign err = {temp[6], temp} - {target_temp[6], target_temp};

  always_comb begin
    // first item after reset seeds the fine level
    if (st.primed) begin
      lvl = st.fine_level;
    end else if (mode_heat) begin
      lvl = FINE_START_HEAT;
    end else begin
      lvl = FINE_START;
    end

    st_next.primed     = 1'b1;
    st_next.polarity   = st.polarity;
    st_next.fine_level = lvl;
    res.duty           = lvl;
    res.fine_region    = 1'b0;
    lvl_up             = lvl;

    if (err > 8'sd1) begin
      st_next.polarity = POL_COOL;
      res.duty         = DUTY_COOL_COARSE;
    end else if (err < -8'sd1) begin
      st_next.polarity = POL_HEAT;
      res.duty         = DUTY_HEAT_COARSE;
    end else begin
      res.fine_region = 1'b1;
      if (mode_cool) begin
        st_next.polarity = POL_COOL;
        lvl_up = lvl + COOL_STEP;
        if (err < 8'sd0) begin
          st_next.fine_level = (lvl >= COOL_FLOOR_TEST) ? lvl - COOL_STEP : COOL_FLOOR;
        end else if (err > 8'sd0) begin
          st_next.fine_level = (lvl_up > DUTY_COOL_COARSE) ? DUTY_COOL_COARSE : lvl_up;
        end
      end else if (mode_heat) begin
        st_next.polarity = POL_HEAT;
        lvl_up = lvl + HEAT_STEP;
        if (err > 8'sd0) begin
          st_next.fine_level = (lvl >= HEAT_FLOOR_TEST) ? lvl - HEAT_STEP : 7'd0;
        end else if (err < 8'sd0) begin
          st_next.fine_level = (lvl_up > HEAT_CAP) ? HEAT_CAP : lvl_up;
        end
      end else begin
        st_next.fine_level = 7'd0;
      end
    end

    res.polarity = st_next.polarity;
  end

endmodule

>>> design/peltier_temperature_regulator.sv
// Samples outside the table need no search; others go through a serial search of the
//   table, one entry per cycle, that stops at entry n (n = 1..66). A new sample is
//   accepted only after the current one's result is registered; the table search is the bottleneck.
// Reset (synchronous, rst high): control cleared, output empty, target and initial
//   back to 20, stored regulator state reads as zero until the first item writes it.
// Depends on ptr_pkg, ptr_ram, ptr_scan, ptr_rules.
`timescale 1ns / 1ps

module peltier_temperature_regulator
  import ptr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // config write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [6:0]           cfg_data,
  // sample item in
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           adc_sample,
  // result item out
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [6:0]    measured_temp,
  output logic [1:0]           direction,
  output logic                 drive_enable,
  output logic [6:0]           duty,
  output logic                 fine_region
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic state;
  logic state_next;

  logic signed [6:0] target_temp;
  logic signed [6:0] initial_temp;

  // handshakes
  logic in_fire;
  logic slot_free;
  logic finish;

  scan_stat_t        scan_stat;
  logic signed [6:0] scan_temp;

  // state memory: one word, read every cycle, written once per item
  logic [STATE_W-1:0] st_rdata;
  logic               st_valid;
  reg_state_t         st_rd;
  reg_state_t         st_wr;
  reg_out_t           rule_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_temp  <= TEMP_CFG_RESET;
      initial_temp <= TEMP_CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TARGET:  target_temp  <= $signed(cfg_data);
        REG_INITIAL: initial_temp <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  // the memory read is registered; the scan never finishes before its data is ready
  assign finish    = (state == ST_BUSY) && scan_stat.done && slot_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_fire) state_next = ST_BUSY;
      ST_BUSY: if (finish) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  ptr_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .start  (in_fire),
    .sample (adc_sample),
    .stat   (scan_stat),
    .temp   (scan_temp)
  );

  ptr_ram #(
    .WIDTH (STATE_W),
    .DEPTH (STATE_DEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (finish),
    .waddr ({STATE_AW{1'b0}}),
    .wdata (st_wr),
    .raddr ({STATE_AW{1'b0}}),
    .rdata (st_rdata)
  );

  // the word is unwritten after reset; it reads as all zero until then
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (finish) begin
      st_valid <= 1'b1;
    end
  end

  assign st_rd = st_valid ? reg_state_t'(st_rdata) : '0;

  ptr_rules u_rules (
    .target_temp  (target_temp),
    .initial_temp (initial_temp),
    .temp         (scan_temp),
    .st           (st_rd),
    .st_next      (st_wr),
    .res          (rule_out)
  );

  // output register; the next item may be accepted while this one waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      measured_temp <= scan_temp;
      direction     <= rule_out.polarity;
      drive_enable  <= 1'b1;
      duty          <= rule_out.duty;
      fine_region   <= rule_out.fine_region;
    end
  end

`ifndef SYNTHESIS
  a_scan_resolves: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BUSY) && !scan_stat.busy |-> scan_stat.done)
    else $error("scan neither running nor done while an item is in flight");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (measured_temp >= TEMP_MIN) && (measured_temp <= TEMP_MAX))
    else $error("measured temperature out of range");

  a_coarse_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !fine_region |-> (duty == DUTY_COOL_COARSE) || (duty == DUTY_HEAT_COARSE))
    else $error("coarse result with unexpected duty");

  // the registered read data lags the first write; check it only with an item in flight
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BUSY) && st_valid |->
      st_rd.primed && (st_rd.fine_level <= DUTY_COOL_COARSE))
    else $error("stored fine level out of bounds");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    finish |=> (state == ST_IDLE) && out_valid)
    else $error("finished item not presented");
`endif

endmodule

>>> tb/ptr_reading_checker.sv
// Checker for the Peltier regulator: tracks register writes, predicts one reading
// per accepted sample and compares it with each accepted result item.
// Depends on ptr_pkg (port widths, register indexes, polarity codes).
`timescale 1ns / 1ps

module ptr_reading_checker
  import ptr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [6:0]           cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [7:0]           adc_sample,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic signed [6:0]    measured_temp,
  input  logic [1:0]           direction,
  input  logic                 drive_enable,
  input  logic [6:0]           duty,
  input  logic                 fine_region,
  output int                   mismatches,
  output int                   pending
);

  localparam int CURVE_LEN = 67;
  localparam int DEG_SHIFT = 10;   // curve entry i reads i - 10 degrees
  localparam logic [7:0] CURVE [0:CURVE_LEN-1] = '{
    8'd247, 8'd240, 8'd234, 8'd227, 8'd221, 8'd214, 8'd208, 8'd202, 8'd196, 8'd190,
    8'd184, 8'd178, 8'd172, 8'd166, 8'd161, 8'd155, 8'd150, 8'd145, 8'd140, 8'd135,
    8'd131, 8'd126, 8'd122, 8'd117, 8'd113, 8'd109, 8'd105, 8'd101, 8'd98,  8'd94,
    8'd91,  8'd87,  8'd84,  8'd81,  8'd78,  8'd76,  8'd74,  8'd71,  8'd68,  8'd66,
    8'd63,  8'd61,  8'd59,  8'd57,  8'd54,  8'd52,  8'd51,  8'd49,  8'd47,  8'd45,
    8'd44,  8'd42,  8'd40,  8'd39,  8'd38,  8'd36,  8'd35,  8'd34,  8'd33,  8'd31,
    8'd30,  8'd29,  8'd28,  8'd27,  8'd26,  8'd25,  8'd24
  };

  localparam logic [6:0] COARSE_COOL_DUTY = 7'd110;
  localparam logic [6:0] COARSE_HEAT_DUTY = 7'd70;
  localparam logic [6:0] TRIM_START       = 7'd50;
  localparam logic [6:0] TRIM_START_HEAT  = 7'd15;
  localparam int         COOL_LOW_TEST    = 25;
  localparam int         COOL_LOW         = 20;
  localparam int         COOL_STEP_SIZE   = 5;
  localparam int         COOL_TOP         = 110;
  localparam int         HEAT_LOW_TEST    = 5;
  localparam int         HEAT_STEP_SIZE   = 2;
  localparam int         HEAT_TOP         = 50;
  localparam logic signed [6:0] REG_RESET_DEG = 7'sd20;
  localparam int         PRINT_CAP        = 100;

  typedef enum logic [1:0] {TRIM_OFF, TRIM_HEAT, TRIM_COOL} trim_mode_t;

  typedef struct packed {
    logic signed [6:0] temp;
    logic [1:0]        dir;
    logic              drive;
    logic [6:0]        duty;
    logic              fine;
  } reading_t;

  logic signed [6:0] target_deg;
  logic signed [6:0] initial_deg;
  logic [6:0]        trim_level;
  logic              primed;
  logic [1:0]        polarity;
  reading_t          expected_readings[$];
  reading_t          want;

  initial mismatches = 0;
  initial pending = 0;

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Nearest curve entry; a tie goes to the later (warmer) entry.
  function automatic int code_to_degrees(input logic [7:0] code);
    int n;
    n = 1;
    if (code >= CURVE[0]) return -DEG_SHIFT;
    if (code < CURVE[CURVE_LEN-1]) return CURVE_LEN - 1 - DEG_SHIFT;
    while (n < CURVE_LEN - 1 && code < CURVE[n]) n++;
    if (int'(code) - int'(CURVE[n]) > int'(CURVE[n-1]) - int'(code)) n--;
    return n - DEG_SHIFT;
  endfunction

  task automatic predict_reading(input logic [7:0] code, output reading_t r);
    int tgt, ini, deg, err, lvl;
    trim_mode_t mode;
    tgt = target_deg;
    ini = initial_deg;
    mode = (tgt < ini) ? TRIM_COOL : (tgt > ini) ? TRIM_HEAT : TRIM_OFF;
    deg = code_to_degrees(code);
    err = deg - tgt;
    if (!primed) begin
      trim_level = (mode == TRIM_HEAT) ? TRIM_START_HEAT : TRIM_START;
      primed = 1'b1;
    end
    r.temp = deg[6:0];
    r.drive = 1'b1;
    if (err > 1) begin
      polarity = POL_COOL;
      r.duty = COARSE_COOL_DUTY;
      r.fine = 1'b0;
    end else if (err < -1) begin
      polarity = POL_HEAT;
      r.duty = COARSE_HEAT_DUTY;
      r.fine = 1'b0;
    end else begin
      r.fine = 1'b1;
      r.duty = trim_level;
      lvl = trim_level;
      case (mode)
        TRIM_COOL: begin
          polarity = POL_COOL;
          if (err < 0) lvl = (lvl >= COOL_LOW_TEST) ? lvl - COOL_STEP_SIZE : COOL_LOW;
          else if (err > 0) lvl = (lvl + COOL_STEP_SIZE > COOL_TOP) ? COOL_TOP
                                                                   : lvl + COOL_STEP_SIZE;
        end
        TRIM_HEAT: begin
          polarity = POL_HEAT;
          if (err > 0) lvl = (lvl >= HEAT_LOW_TEST) ? lvl - HEAT_STEP_SIZE : 0;
          else if (err < 0) lvl = (lvl + HEAT_STEP_SIZE > HEAT_TOP) ? HEAT_TOP
                                                                   : lvl + HEAT_STEP_SIZE;
        end
        default: lvl = 0;
      endcase
      trim_level = lvl[6:0];
    end
    r.dir = polarity;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      target_deg = REG_RESET_DEG;
      initial_deg = REG_RESET_DEG;
      trim_level = '0;
      primed = 1'b0;
      polarity = POL_NONE;
      expected_readings.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TARGET) target_deg = cfg_data;
        else if (cfg_index == REG_INITIAL) initial_deg = cfg_data;
      end
      // Compare before predicting: a result never belongs to a sample taken this edge.
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected (temp %0d duty %0d)",
                                    measured_temp, duty));
        end else begin
          want = expected_readings.pop_front();
          if (measured_temp !== want.temp)
            report_mismatch($sformatf("measured_temp got %0d expected %0d",
                                      measured_temp, want.temp));
          if (direction !== want.dir)
            report_mismatch($sformatf("direction got %0d expected %0d",
                                      direction, want.dir));
          if (drive_enable !== want.drive)
            report_mismatch($sformatf("drive_enable got %0b expected %0b",
                                      drive_enable, want.drive));
          if (duty !== want.duty)
            report_mismatch($sformatf("duty got %0d expected %0d", duty, want.duty));
          if (fine_region !== want.fine)
            report_mismatch($sformatf("fine_region got %0b expected %0b",
                                      fine_region, want.fine));
        end
      end
      if (in_valid && in_ready) begin
        predict_reading(adc_sample, want);
        expected_readings.push_back(want);
      end
    end
    pending <= expected_readings.size();
  end

endmodule

>>> tb/tb_top.sv
// Top of the Peltier regulator testbench: clock, reset, register phases and sample
// stimulus with random idling; the verdict comes from ptr_reading_checker.
// Depends on ptr_pkg, peltier_temperature_regulator and ptr_reading_checker.
`timescale 1ns / 1ps

module tb_top;
  import ptr_pkg::*;

  localparam int IDLE_PCT   = 37;       // chance in 100 that a side idles in a cycle
  localparam int STALL_LEN  = 400;      // long receiver hold-off, cycles
  localparam int TAIL_LEN   = 100;      // quiet cycles after the last result
  localparam int DRIFT_SPAN = 30;       // items per drift setting

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TARGET;
  logic [6:0]           cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           adc_sample = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [6:0]    measured_temp;
  logic [1:0]           direction;
  logic                 drive_enable;
  logic [6:0]           duty;
  logic                 fine_region;
  int                   mismatches;
  int                   pending;

  bit                   steady = 1'b0;   // when set, neither side idles
  int                   hold_off = 0;    // receiver stall request, in cycles
  int                   drift = 0;       // bias of near-target samples, -1..1 entries
  logic signed [6:0]    cur_target = 7'sd20;

  peltier_temperature_regulator u_dut (.*);
  ptr_reading_checker u_chk (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("** peltier_temperature_regulator: FAILED **");
    $finish;
  end

  // Receiver: random stalls, none while steady, and a long hold-off on request
  // so the result register fills and the block backs up its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Both registers in one burst; cfg_valid only drops after the second item.
  task automatic configure(input logic signed [6:0] tgt, input logic signed [6:0] ini);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TARGET;
    cfg_data  <= tgt;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_INITIAL;
    cfg_data  <= ini;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_target = tgt;
  endtask

  // One sample item. Returns at the edge where it was taken, valid still high,
  // so the next call either keeps valid up with new data or opens a gap.
  task automatic send_sample(input logic [7:0] code);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid   <= 1'b1;
    adc_sample <= code;
    do @(posedge clk); while (!in_ready);
  endtask

  // Block is idle once every predicted reading has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Mostly codes close to the target's curve entry so the fine rule gets real
  // exercise; the rest are anywhere, or near either clamp.
  function automatic logic [7:0] pick_sample();
    int roll, idx, code;
    roll = $urandom_range(99);
    if (roll < 15) return 8'($urandom_range(255));
    if (roll < 18) return 8'($urandom_range(23));
    if (roll < 22) return 8'($urandom_range(255, 240));
    idx = int'(cur_target) + int'(TEMP_OFFSET);
    idx += ($urandom_range(9) < 6) ? drift : int'($urandom_range(4)) - 2;
    if (idx < 0) idx = 0;
    if (idx > int'(VOLT_LAST)) idx = int'(VOLT_LAST);
    code = int'(volt_entry(IDX_W'(idx)));
    // off-entry codes land between entries, ties included
    if ($urandom_range(3) == 0) code += int'($urandom_range(2)) - 1;
    if (code < 0) code = 0;
    if (code > 255) code = 255;
    return 8'(code);
  endfunction

  task automatic send_batch(input int n);
    for (int k = 0; k < n; k++) begin
      // a steady drift pushes the trim level to its caps and floors
      if (k % DRIFT_SPAN == 0) drift = int'($urandom_range(2)) - 1;
      send_sample(pick_sample());
    end
  endtask

  task automatic run_phase(input logic signed [6:0] tgt, input logic signed [6:0] ini,
                           input int n);
    configure(tgt, ini);
    send_batch(n);
    drain();
  endtask

  initial begin
    logic signed [6:0] tgt, ini;
    logic [7:0] heat_codes[$];

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed, heat trim (target 25 above initial 20): first item primes the
    // trim level at the heat start value. Codes: above the top entry, the top
    // entry, codes rounding to it and to the next entry, a tie between entries, the bottom entry,
    // below it, zero, then target, +1, -1, a tie onto target, and both coarse sides.
    heat_codes = '{8'd255, 8'd247, 8'd246, 8'd244, 8'd243, 8'd237, 8'd24, 8'd23,
                   8'd0, 8'd76, 8'd74, 8'd78, 8'd77, 8'd71, 8'd81, 8'd74, 8'd74};
    configure(7'sd25, 7'sd20);
    foreach (heat_codes[i]) send_sample(heat_codes[i]);
    drain();

    // Cool trim, then trim off (target equals initial).
    configure(7'sd25, 7'sd30);
    send_sample(8'd76);
    send_sample(8'd74);
    send_sample(8'd78);
    send_sample(8'd81);
    send_sample(8'd71);
    drain();
    configure(7'sd25, 7'sd25);
    send_sample(8'd76);
    send_sample(8'd74);
    drain();

    // Random phases across trim modes and register extremes.
    run_phase(7'sd20, 7'sd20, 100);

    steady = 1'b1;                        // long stretch with no idling
    run_phase(7'sd10, 7'sd30, 150);
    steady = 1'b0;

    configure(7'sd40, 7'sd5);
    send_batch(70);
    steady = 1'b1;
    hold_off = STALL_LEN;                 // receiver blocks, sender keeps offering
    send_batch(20);
    steady = 1'b0;
    send_batch(60);
    drain();

    run_phase(-7'sd10, 7'sd56, 120);
    run_phase(7'sd56, -7'sd10, 120);
    run_phase(-7'sd64, 7'sd63, 60);       // full register range, always coarse
    run_phase(7'sd63, -7'sd64, 60);

    repeat (4) begin
      tgt = 7'($urandom_range(66)) - 7'sd10;
      case ($urandom_range(2))
        0: ini = tgt;
        1: ini = tgt + (($urandom_range(1) == 1) ? 7'sd1 : -7'sd1);
        default: ini = 7'($urandom_range(127));
      endcase
      run_phase(tgt, ini, 135);
    end

    // Watch for stray results before the verdict.
    repeat (TAIL_LEN) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("** peltier_temperature_regulator: PASSED **");
    end else begin
      $display("** peltier_temperature_regulator: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
design/ptr_pkg.sv
design/ptr_ram.sv
design/ptr_scan.sv
design/ptr_rules.sv
design/peltier_temperature_regulator.sv
tb/ptr_reading_checker.sv
tb/tb_top.sv
